// ===== hdl/dtsv_pkg.sv =====
// Shared types, constants and helpers for the date/time string validator.
// No dependencies; every other file in hdl/ refers to this package.
package dtsv_pkg;

  // Depth of the queue between the character front end and the checker
  localparam int unsigned QueueDepth = 2;

  // Character position counter saturates here
  localparam logic [4:0] PosSat = 5'd31;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [13:0] YearDefault = 14'd1970;
  localparam logic [13:0] YearLimit   = 14'd9999;
  localparam logic [6:0]  HourLimit   = 7'd24;
  localparam logic [6:0]  SixtyLimit  = 7'd60;
  localparam logic [6:0]  MonthMax    = 7'd12;

  typedef enum logic [2:0] {
    FORM_YM   = 3'd0,
    FORM_DATE = 3'd1,
    FORM_HM   = 3'd2,
    FORM_HMS  = 3'd3,
    FORM_DT   = 3'd4
  } form_e;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [2:0]  form;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
  } out_t;

  // One finished string as seen by the checker. hi2 holds the first two
  // digits: year century in the date family, hour in the time family.
  typedef struct packed {
    logic       bad;
    form_e      form;
    logic [6:0] hi2;
    logic [6:0] ylo;
    logic [6:0] mon;
    logic [6:0] day;
    logic [6:0] hr;
    logic [6:0] mi;
    logic [6:0] sec;
  } rec_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
    logic [4:0] dim;
    unique case (mon)
      4'd2:                      dim = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   dim = 5'd30;
      default:                   dim = 5'd31;
    endcase
    return dim;
  endfunction

endpackage

// ===== hdl/date_time_string_validator.sv =====
// Top level of the date/time string validator: front end, queue, checker.
// Depends on dtsv_pkg, dtsv_front, dtsv_fifo and dtsv_back.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------------
//   input    | in        | in_valid_i / in_stall_o    | in_data_i  (one character)
//   result   | out       | out_valid_o / out_stall_i  | out_data_o (one per string)
//
// One character is taken per cycle while in_stall_o is low; the front end's per-character digit
// accumulate and position check set that figure. out_valid_o rises once a string's last
// character has been accepted and its result has passed the queue, then the output register.
// Reset clears the position counter, queue and output valid flag; no warm-up.
// in_stall_o rises only when the queue is full, which happens once QueueDepth
// finished strings wait behind a result that the result channel stalls.
module date_time_string_validator #(
  parameter int unsigned QueueDepth = dtsv_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dtsv_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dtsv_pkg::out_t out_data_o
);

  logic           accept, push, full, pop, nonempty;
  dtsv_pkg::rec_t rec_in, rec_head;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  dtsv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (in_data_i),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  dtsv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rec_i      (rec_in),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .rec_o      (rec_head)
  );

  dtsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (nonempty),
    .rec_i       (rec_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/dtsv_front.sv =====
// Front end: takes one character per transaction, checks its position,
// accumulates two-digit fields and classifies the string at its last character.
// Depends on dtsv_pkg.
module dtsv_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  dtsv_pkg::in_t  char_i,
  output logic           push_o,
  output dtsv_pkg::rec_t rec_o
);

  logic [4:0] pos_q, pos_d;
  logic       err_q, err_d;
  logic       tb_q, tb_d;
  logic [6:0] hi2_q, hi2_d, ylo_q, ylo_d, mon_q, mon_d, day_q, day_d;
  logic [6:0] hr_q, hr_d, mi_q, mi_d, sec_q, sec_d;

  logic [6:0] hi2_n, ylo_n, mon_n, day_n, hr_n, mi_n, sec_n;
  logic       tb_n;
  logic       ok, dig, len_bad, last;
  logic [7:0] c;
  logic [3:0] d;
  dtsv_pkg::form_e form;

  function automatic logic [6:0] push_digit(input logic [6:0] old, input logic [3:0] dv,
                                            input logic first);
    logic [6:0] res;
    res = first ? {3'd0, dv} : (7'((old << 3) + (old << 1)) + {3'd0, dv});
    return res;
  endfunction

  assign c    = char_i.ascii_char;
  assign last = char_i.last_char;
  assign dig  = (c >= dtsv_pkg::CharZero) && (c <= dtsv_pkg::CharNine);
  assign d    = dig ? 4'(c - dtsv_pkg::CharZero) : 4'd0;

  // Position check and field accumulation
  always_comb begin
    ok    = 1'b0;
    tb_n  = tb_q;
    hi2_n = hi2_q;
    ylo_n = ylo_q;
    mon_n = mon_q;
    day_n = day_q;
    hr_n  = hr_q;
    mi_n  = mi_q;
    sec_n = sec_q;
    priority if (pos_q < 5'd2) begin
      ok = dig;
      if (dig) begin
        hi2_n = push_digit(hi2_q, d, pos_q == 5'd0);
      end
    end else if (pos_q == 5'd2) begin
      if (c == dtsv_pkg::CharColon) begin
        tb_n = 1'b1;
        ok   = 1'b1;
      end else begin
        ok = dig;
        if (dig) begin
          ylo_n = push_digit(ylo_q, d, 1'b1);
        end
      end
    end else if (tb_q) begin
      priority if (pos_q == 5'd5) begin
        ok = (c == dtsv_pkg::CharColon);
      end else if (pos_q < 5'd8) begin
        ok = dig;
        if (dig) begin
          if (pos_q <= 5'd4) begin
            mi_n = push_digit(mi_q, d, pos_q == 5'd3);
          end else begin
            sec_n = push_digit(sec_q, d, pos_q == 5'd6);
          end
        end
      end else begin
        ok = 1'b0;
      end
    end else begin
      priority if (pos_q == 5'd4 || pos_q == 5'd7) begin
        ok = (c == dtsv_pkg::CharDash);
      end else if (pos_q == 5'd10) begin
        ok = (c == dtsv_pkg::CharSpace);
      end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
        ok = (c == dtsv_pkg::CharColon);
      end else if (pos_q < 5'd19) begin
        ok = dig;
        if (dig) begin
          priority if (pos_q == 5'd3) begin
            ylo_n = push_digit(ylo_q, d, 1'b0);
          end else if (pos_q <= 5'd6) begin
            mon_n = push_digit(mon_q, d, pos_q == 5'd5);
          end else if (pos_q <= 5'd9) begin
            day_n = push_digit(day_q, d, pos_q == 5'd8);
          end else if (pos_q <= 5'd12) begin
            hr_n = push_digit(hr_q, d, pos_q == 5'd11);
          end else if (pos_q <= 5'd15) begin
            mi_n = push_digit(mi_q, d, pos_q == 5'd14);
          end else begin
            sec_n = push_digit(sec_q, d, pos_q == 5'd17);
          end
        end
      end else begin
        ok = 1'b0;
      end
    end
  end

  // Classify by length and family
  always_comb begin
    len_bad = 1'b0;
    form    = dtsv_pkg::FORM_YM;
    if (tb_n) begin
      priority if (pos_q == 5'd4) begin
        form = dtsv_pkg::FORM_HM;
      end else if (pos_q == 5'd7) begin
        form = dtsv_pkg::FORM_HMS;
      end else begin
        len_bad = 1'b1;
      end
    end else begin
      priority if (pos_q == 5'd6) begin
        form = dtsv_pkg::FORM_YM;
      end else if (pos_q == 5'd9) begin
        form = dtsv_pkg::FORM_DATE;
      end else if (pos_q == 5'd18) begin
        form = dtsv_pkg::FORM_DT;
      end else begin
        len_bad = 1'b1;
      end
    end
  end

  always_comb begin
    rec_o.bad  = err_q | ~ok | len_bad;
    rec_o.form = form;
    rec_o.hi2  = hi2_n;
    rec_o.ylo  = ylo_n;
    rec_o.mon  = mon_n;
    rec_o.day  = day_n;
    rec_o.hr   = hr_n;
    rec_o.mi   = mi_n;
    rec_o.sec  = sec_n;
    push_o     = accept_i & last;
  end

  // Next state: clear everything after the last character
  always_comb begin
    pos_d = pos_q;
    err_d = err_q;
    tb_d  = tb_q;
    hi2_d = hi2_q;
    ylo_d = ylo_q;
    mon_d = mon_q;
    day_d = day_q;
    hr_d  = hr_q;
    mi_d  = mi_q;
    sec_d = sec_q;
    if (accept_i) begin
      if (last) begin
        pos_d = '0;
        err_d = 1'b0;
        tb_d  = 1'b0;
        hi2_d = '0;
        ylo_d = '0;
        mon_d = '0;
        day_d = '0;
        hr_d  = '0;
        mi_d  = '0;
        sec_d = '0;
      end else begin
        pos_d = (pos_q == dtsv_pkg::PosSat) ? pos_q : pos_q + 5'd1;
        err_d = err_q | ~ok;
        tb_d  = tb_n;
        hi2_d = hi2_n;
        ylo_d = ylo_n;
        mon_d = mon_n;
        day_d = day_n;
        hr_d  = hr_n;
        mi_d  = mi_n;
        sec_d = sec_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      err_q <= 1'b0;
      tb_q  <= 1'b0;
      hi2_q <= '0;
      ylo_q <= '0;
      mon_q <= '0;
      day_q <= '0;
      hr_q  <= '0;
      mi_q  <= '0;
      sec_q <= '0;
    end else begin
      pos_q <= pos_d;
      err_q <= err_d;
      tb_q  <= tb_d;
      hi2_q <= hi2_d;
      ylo_q <= ylo_d;
      mon_q <= mon_d;
      day_q <= day_d;
      hr_q  <= hr_d;
      mi_q  <= mi_d;
      sec_q <= sec_d;
    end
  end

endmodule

// ===== hdl/dtsv_fifo.sv =====
// Short register queue of classified strings between front end and checker.
// Depends on dtsv_pkg.
module dtsv_fifo #(
  parameter int unsigned Depth = dtsv_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dtsv_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           nonempty_o,
  output dtsv_pkg::rec_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dtsv_pkg::rec_t  entry_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign nonempty_o = (cnt_q != '0);
  assign rec_o      = entry_q[rptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & nonempty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= rec_i;
    end
  end

endmodule

// ===== hdl/dtsv_back.sv =====
// Checker: range checks on a classified string (calendar and clock limits)
// and the output register toward the result channel. Depends on dtsv_pkg.
module dtsv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  input  dtsv_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dtsv_pkg::out_t out_data_o
);

  logic           out_valid_q, out_valid_d;
  dtsv_pkg::out_t out_data_q, res;

  logic [13:0] year;
  logic        leap, is_date, is_time, date_ok, time_ok, valid;
  logic [6:0]  dy, h, s;
  logic [4:0]  dim;

  always_comb begin
    year    = 14'(rec_i.hi2 * 14'd100) + {7'd0, rec_i.ylo};
    // Divisible by 100 exactly when the low two digits are zero
    leap    = (rec_i.ylo[1:0] == 2'd0) && ((rec_i.ylo != '0) || (rec_i.hi2[1:0] == 2'd0));
    is_date = (rec_i.form == dtsv_pkg::FORM_YM) || (rec_i.form == dtsv_pkg::FORM_DATE) ||
              (rec_i.form == dtsv_pkg::FORM_DT);
    is_time = (rec_i.form == dtsv_pkg::FORM_HM) || (rec_i.form == dtsv_pkg::FORM_HMS) ||
              (rec_i.form == dtsv_pkg::FORM_DT);
    dy      = (rec_i.form == dtsv_pkg::FORM_YM) ? 7'd1 : rec_i.day;
    h       = (rec_i.form == dtsv_pkg::FORM_DT) ? rec_i.hr : rec_i.hi2;
    s       = (rec_i.form == dtsv_pkg::FORM_HM) ? 7'd0 : rec_i.sec;
    dim     = dtsv_pkg::days_in_month(rec_i.mon[3:0], leap);
    date_ok = (year != '0) && (year < dtsv_pkg::YearLimit) && (rec_i.mon != '0) &&
              (rec_i.mon <= dtsv_pkg::MonthMax) && (dy != '0) && (dy <= {2'd0, dim});
    time_ok = (h < dtsv_pkg::HourLimit) && (rec_i.mi < dtsv_pkg::SixtyLimit) &&
              (s < dtsv_pkg::SixtyLimit);
    valid   = ~rec_i.bad && (~is_date || date_ok) && (~is_time || time_ok);

    res = '0;
    if (valid) begin
      res.valid_res  = 1'b1;
      res.form       = rec_i.form;
      res.out_year   = is_date ? year : dtsv_pkg::YearDefault;
      res.out_month  = is_date ? rec_i.mon[3:0] : 4'd1;
      res.out_day    = dy[4:0];
      res.out_hour   = is_time ? h[4:0] : 5'd0;
      res.out_minute = is_time ? rec_i.mi[5:0] : 6'd0;
      res.out_second = is_time ? s[5:0] : 6'd0;
      if (!is_date) begin
        res.out_day = 5'd1;
      end
    end
  end

  // Load a new result whenever the output register is empty or being drained
  assign pop_o = rec_valid_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = rec_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
